FILE: rtl/srrr_pkg.sv
// ----------------------------------------------------------------------------
// srrr_pkg
// Types and constants shared by the sequence range reverse/rotate block.
// ----------------------------------------------------------------------------
package srrr_pkg;

  // Store geometry
  localparam int DEPTH     = 1024;
  localparam int WORD_BITS = 32;
  localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS  = $clog2(DEPTH + 1);

  // Fixed field widths of the command and result words
  localparam int IDX_BITS  = 10;
  localparam int DATA_BITS = 32;

  typedef enum logic [1:0] {
    CMD_APPEND  = 2'd0,
    CMD_ROTATE  = 2'd1,
    CMD_REVERSE = 2'd2,
    CMD_READ    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    cmd_t                        command;
    logic [IDX_BITS-1:0]         first_index;
    logic [IDX_BITS-1:0]         last_index;
    logic signed [DATA_BITS-1:0] word_in;
  } req_t;

  typedef struct packed {
    status_t                     status;
    logic signed [DATA_BITS-1:0] word_out;
  } res_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ_WAIT,
    S_ROT,
    S_ROT_LAST,
    S_REV_A,
    S_REV_B
  } state_t;

endpackage

FILE: rtl/sequence_range_reverse_rotate.sv
// ----------------------------------------------------------------------------
// sequence_range_reverse_rotate
// Ordered word store with append, range rotate-right, range reverse and read.
// ----------------------------------------------------------------------------
// Append, error and one-element range results come in the cycle after the
//   command is taken; read, rotate and reverse run in their own states.
// Throughput: one command at a time (busy high while working); the range
//   commands are bound by the single RAM write port, one word move per cycle.
// Results show for one cycle with result_valid; the receiver cannot stall.
// Reset clears the length and the control state; the store is not cleared.
module sequence_range_reverse_rotate
  import srrr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t request,
  output logic result_valid,
  output res_t result
);

  state_t state, state_next;

  logic [CNT_BITS-1:0]  count, count_next;
  logic [IDX_BITS-1:0]  lo, lo_next, hi, hi_next, ptr, ptr_next;
  logic [IDX_BITS-1:0]  plo, plo_next, phi, phi_next;
  logic                 pv, pv_next, issue, issue_next;
  logic [WORD_BITS-1:0] moved, moved_next, tmp, tmp_next;
  logic                 res_valid_next;
  res_t                 res_next;

  // RAM ports
  logic                 we;
  logic [ADDR_BITS-1:0] waddr, raddr;
  logic [WORD_BITS-1:0] wdata, rdata;

  // command decode
  logic accept, range_ok, read_ok, full;

  srrr_ram #(
    .ADDR_W (ADDR_BITS),
    .DATA_W (WORD_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  assign full     = (count == CNT_BITS'(DEPTH));
  assign range_ok = (request.first_index <= request.last_index) &&
                    (CNT_BITS'(request.last_index) < count);
  assign read_ok  = (CNT_BITS'(request.first_index) < count);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      pv           <= 1'b0;
      issue        <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      count        <= count_next;
      pv           <= pv_next;
      issue        <= issue_next;
      result_valid <= res_valid_next;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    lo     <= lo_next;
    hi     <= hi_next;
    ptr    <= ptr_next;
    plo    <= plo_next;
    phi    <= phi_next;
    moved  <= moved_next;
    tmp    <= tmp_next;
    result <= res_next;
  end

  // sequencer
  always_comb begin
    state_next     = state;
    count_next     = count;
    lo_next        = lo;
    hi_next        = hi;
    ptr_next       = ptr;
    plo_next       = plo;
    phi_next       = phi;
    pv_next        = pv;
    issue_next     = issue;
    moved_next     = moved;
    tmp_next       = tmp;
    res_valid_next = 1'b0;
    res_next       = result;
    we             = 1'b0;
    waddr          = ADDR_BITS'(lo);
    wdata          = rdata;
    raddr          = ADDR_BITS'(lo);

    case (state)
      S_IDLE: begin
        if (accept) begin
          res_next.status   = ST_OK;
          res_next.word_out = '0;
          lo_next           = request.first_index;
          hi_next           = request.last_index;
          ptr_next          = request.last_index;
          pv_next           = 1'b0;
          issue_next        = 1'b1;
          case (request.command)
            CMD_APPEND: begin
              res_valid_next = 1'b1;
              if (full) begin
                res_next.status = ST_FULL;
              end else begin
                we         = 1'b1;
                waddr      = ADDR_BITS'(count);
                wdata      = WORD_BITS'(request.word_in);
                count_next = count + 1'b1;
              end
            end
            CMD_ROTATE, CMD_REVERSE: begin
              if (!range_ok) begin
                res_next.status = ST_RANGE;
                res_valid_next  = 1'b1;
              end else if (request.first_index == request.last_index) begin
                res_valid_next = 1'b1;
              end else if (request.command == CMD_ROTATE) begin
                state_next = S_ROT;
              end else begin
                state_next = S_REV_A;
              end
            end
            CMD_READ: begin
              if (!read_ok) begin
                res_next.status = ST_RANGE;
                res_valid_next  = 1'b1;
              end else begin
                raddr      = ADDR_BITS'(request.first_index);
                state_next = S_READ_WAIT;
              end
            end
            default: begin
              res_valid_next = 1'b1;
            end
          endcase
        end
      end

      // read data is back from the RAM
      S_READ_WAIT: begin
        res_next.word_out = DATA_BITS'(rdata);
        res_valid_next    = 1'b1;
        state_next        = S_IDLE;
      end

      // read hi down to lo; each word read but the one at hi lands one slot up
      S_ROT: begin
        if (pv) begin
          if (plo == hi) begin
            moved_next = rdata;
          end else begin
            we    = 1'b1;
            waddr = ADDR_BITS'(plo + 1'b1);
            wdata = rdata;
          end
        end
        if (issue) begin
          raddr    = ADDR_BITS'(ptr);
          plo_next = ptr;
          pv_next  = 1'b1;
          if (ptr == lo) begin
            issue_next = 1'b0;
          end else begin
            ptr_next = ptr - 1'b1;
          end
        end else begin
          pv_next    = 1'b0;
          state_next = S_ROT_LAST;
        end
      end

      // old last word goes to the front of the range
      S_ROT_LAST: begin
        we             = 1'b1;
        waddr          = ADDR_BITS'(lo);
        wdata          = moved;
        res_valid_next = 1'b1;
        state_next     = S_IDLE;
      end

      // swap phase A: write previous low slot, read current low word
      S_REV_A: begin
        if (pv) begin
          we    = 1'b1;
          waddr = ADDR_BITS'(plo);
          wdata = rdata;
        end
        raddr      = ADDR_BITS'(lo);
        state_next = S_REV_B;
      end

      // swap phase B: write previous high slot, read current high word
      S_REV_B: begin
        if (pv) begin
          we    = 1'b1;
          waddr = ADDR_BITS'(phi);
          wdata = tmp;
        end
        if (lo < hi) begin
          raddr      = ADDR_BITS'(hi);
          tmp_next   = rdata;
          plo_next   = lo;
          phi_next   = hi;
          lo_next    = lo + 1'b1;
          hi_next    = hi - 1'b1;
          pv_next    = 1'b1;
          state_next = S_REV_A;
        end else begin
          pv_next        = 1'b0;
          res_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/srrr_ram.sv
// ----------------------------------------------------------------------------
// srrr_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module srrr_ram #(
  parameter int ADDR_W = 10,
  parameter int DATA_W = 32
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: test/sequence_result_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sequence_result_check
// Watches the command and result channels of the sequence store, keeps a
// mirror of the sequence, predicts one result per accepted command word and
// compares every result word with the oldest prediction.
// ----------------------------------------------------------------------------
module sequence_result_check
  import srrr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic busy,
  input  req_t request,
  input  logic result_valid,
  input  res_t result,
  output int   fail_count,
  output int   pending
);

  localparam int REPORT_LIMIT = 10;

  // Mirror of the sequence and the results still owed by the block
  logic [WORD_BITS-1:0] mirror_words [DEPTH];
  int unsigned          mirror_len;
  res_t                 owed_results [$];
  int unsigned          results_seen;

  // Apply one command word to the mirror and return the result it owes
  function automatic res_t apply_command(req_t w);
    res_t                 r;
    logic [WORD_BITS-1:0] held;
    int unsigned          lo;
    int unsigned          hi;
    r.status   = ST_OK;
    r.word_out = '0;
    lo = w.first_index;
    hi = w.last_index;
    case (w.command)
      CMD_APPEND: begin
        if (mirror_len >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          mirror_words[mirror_len] = WORD_BITS'(w.word_in);
          mirror_len++;
        end
      end
      CMD_ROTATE, CMD_REVERSE: begin
        if (lo > hi || hi >= mirror_len) begin
          r.status = ST_RANGE;
        end else if (w.command == CMD_ROTATE) begin
          // last word of the range moves to its front
          held = mirror_words[hi];
          for (int k = hi; k > lo; k--) mirror_words[k] = mirror_words[k - 1];
          mirror_words[lo] = held;
        end else begin
          while (lo < hi) begin
            held             = mirror_words[lo];
            mirror_words[lo] = mirror_words[hi];
            mirror_words[hi] = held;
            lo++;
            hi--;
          end
        end
      end
      CMD_READ: begin
        if (lo >= mirror_len) r.status = ST_RANGE;
        else r.word_out = DATA_BITS'(mirror_words[lo]);
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  task automatic note_mismatch(string msg);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // Results are checked before a new command is taken: a result never
  // belongs to the word accepted at the same edge.
  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      mirror_len   = 0;
      results_seen = 0;
      fail_count   = 0;
      owed_results.delete();
    end else begin
      if (result_valid) begin
        results_seen++;
        if (owed_results.size() == 0) begin
          note_mismatch($sformatf("result %0d with none owed: status %0d word %h",
                                  results_seen, result.status, result.word_out));
        end else begin
          want = owed_results.pop_front();
          if (result.status !== want.status)
            note_mismatch($sformatf("result %0d status: expected %0d, got %0d",
                                    results_seen, want.status, result.status));
          if (result.word_out !== want.word_out)
            note_mismatch($sformatf("result %0d word_out: expected %h, got %h",
                                    results_seen, want.word_out, result.word_out));
        end
      end
      if (start && !busy) owed_results.insert(owed_results.size(), apply_command(request));
    end
    pending = owed_results.size();
  end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives command words into the sequence store: a directed opening over the
// edge cases, random commands on a growing sequence, ranges over the whole
// sequence and more random commands on it. Results are checked by
// sequence_result_check; this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
  import srrr_pkg::*;

  localparam int STALL_LIMIT  = 8000;
  localparam int DRAIN_CYCLES = 1100;
  localparam int GROW_WORDS   = 300;
  localparam int FULL_WORDS   = 280;
  localparam int CALM_WORDS   = 60;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic result_valid;
  req_t request;
  res_t result;
  int   fail_count;
  int   pending;

  // Stimulus bookkeeping
  int unsigned seq_len;
  int unsigned peak_len;
  int unsigned full_hits;
  int unsigned cmd_seen [4];
  int unsigned stall_cycles;
  bit          idle_on;

  sequence_range_reverse_rotate dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .request      (request),
    .result_valid (result_valid),
    .result       (result)
  );

  sequence_result_check result_check (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .request      (request),
    .result_valid (result_valid),
    .result       (result),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog: cycles with neither a command nor a result accepted
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic req_t make_word(cmd_t c, int unsigned lo, int unsigned hi,
                                     logic [31:0] v);
    req_t w;
    w.command     = c;
    w.first_index = IDX_BITS'(lo);
    w.last_index  = IDX_BITS'(hi);
    w.word_in     = v;
    return w;
  endfunction

  // Random command: mostly well-formed ranges and reads on the current
  // sequence, the rest raw indices over the whole field.
  function automatic req_t pick_word(int unsigned len, int unsigned append_pct);
    req_t        w;
    int unsigned roll;
    int unsigned lo;
    int unsigned room;
    int unsigned span;
    w    = make_word(CMD_APPEND, $urandom_range(0, 1023), $urandom_range(0, 1023),
                     $urandom);
    roll = $urandom_range(0, 99);
    if (roll < append_pct || len == 0) return w;
    if (roll < append_pct + (100 - append_pct) * 6 / 10) begin
      w.command = ($urandom_range(0, 1) == 0) ? CMD_ROTATE : CMD_REVERSE;
      if ($urandom_range(0, 9) != 0) begin
        lo   = $urandom_range(0, len - 1);
        room = len - 1 - lo;
        span = ($urandom_range(0, 19) == 0) ? room : 15;
        if (span > room) span = room;
        w.first_index = IDX_BITS'(lo);
        w.last_index  = IDX_BITS'(lo + $urandom_range(0, span));
      end
    end else begin
      w.command = CMD_READ;
      if ($urandom_range(0, 9) != 0) w.first_index = IDX_BITS'($urandom_range(0, len - 1));
    end
    return w;
  endfunction

  // Present one word at a falling edge and hold it until taken
  task automatic send_word(input req_t w);
    start   <= 1'b1;
    request <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    cmd_seen[w.command]++;
    if (w.command == CMD_APPEND) begin
      if (seq_len < DEPTH) seq_len++;
      else full_hits++;
    end
    if (seq_len > peak_len) peak_len = seq_len;
    @(negedge clk);
  endtask

  // Random sender gap with start low and junk on the request bus
  task automatic take_gap();
    if (idle_on && $urandom_range(0, 3) == 0) begin
      start   <= 1'b0;
      request <= make_word(cmd_t'($urandom_range(0, 3)), $urandom_range(0, 1023),
                           $urandom_range(0, 1023), $urandom);
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
  endtask

  initial begin
    rst       = 1'b1;
    start     = 1'b0;
    request   = '0;
    seq_len   = 0;
    peak_len  = 0;
    full_hits = 0;
    idle_on   = 1'b0;
    foreach (cmd_seen[i]) cmd_seen[i] = 0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // Directed: empty store, value extremes, bad ranges, one-word ranges
    send_word(make_word(CMD_READ, 0, $urandom_range(0, 1023), $urandom));
    send_word(make_word(CMD_ROTATE, 0, 0, $urandom));
    send_word(make_word(CMD_REVERSE, 0, 0, $urandom));
    send_word(make_word(CMD_APPEND, 1023, 1023, 32'h8000_0000));
    send_word(make_word(CMD_APPEND, 0, 0, 32'h7FFF_FFFF));
    send_word(make_word(CMD_APPEND, $urandom_range(0, 1023), 0, 32'h0000_0000));
    send_word(make_word(CMD_APPEND, 0, $urandom_range(0, 1023), 32'hFFFF_FFFF));
    send_word(make_word(CMD_APPEND, 0, 0, 32'h5A5A_A5A5));
    send_word(make_word(CMD_READ, 0, 1023, $urandom));
    send_word(make_word(CMD_READ, 4, 0, $urandom));
    send_word(make_word(CMD_READ, 5, 0, $urandom));
    send_word(make_word(CMD_ROTATE, 1, 4, $urandom));
    send_word(make_word(CMD_REVERSE, 0, 4, $urandom));
    send_word(make_word(CMD_ROTATE, 2, 2, $urandom));
    send_word(make_word(CMD_REVERSE, 3, 3, $urandom));
    send_word(make_word(CMD_REVERSE, 3, 1, $urandom));
    send_word(make_word(CMD_ROTATE, 0, 5, $urandom));
    send_word(make_word(CMD_ROTATE, 1023, 1023, $urandom));
    send_word(make_word(CMD_READ, 1023, 1023, $urandom));
    send_word(make_word(CMD_REVERSE, 0, 1, $urandom));
    for (int i = 0; i < 5; i++) send_word(make_word(CMD_READ, i, $urandom_range(0, 1023),
                                                    $urandom));

    // Random commands on a growing sequence
    for (int n = 0; n < GROW_WORDS; n++) begin
      if (n % 32 == 0) idle_on = ($urandom_range(0, 3) != 0);
      take_gap();
      send_word(pick_word(seq_len, 35));
    end

    // Sender holds off until the block has answered everything
    start <= 1'b0;
    while (pending != 0) @(negedge clk);

    // Whole-sequence ranges, the last index and one past it
    idle_on = 1'b1;
    send_word(make_word(CMD_READ, seq_len - 1, 0, $urandom));
    send_word(make_word(CMD_ROTATE, 0, seq_len - 1, $urandom));
    send_word(make_word(CMD_READ, 0, 0, $urandom));
    send_word(make_word(CMD_REVERSE, 0, seq_len - 1, $urandom));
    send_word(make_word(CMD_READ, seq_len - 1, 0, $urandom));
    send_word(make_word(CMD_ROTATE, seq_len - 2, seq_len - 1, $urandom));
    send_word(make_word(CMD_REVERSE, seq_len - 1, seq_len - 1, $urandom));
    send_word(make_word(CMD_READ, seq_len, 0, $urandom));

    // Random commands on the grown sequence; the tail runs without gaps
    for (int n = 0; n < FULL_WORDS; n++) begin
      if (n % 32 == 0) idle_on = ($urandom_range(0, 3) != 0);
      if (n >= FULL_WORDS - CALM_WORDS) idle_on = 1'b0;
      take_gap();
      send_word(pick_word(seq_len, 5));
    end

    // Drain
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Sent %0d commands: %0d append, %0d rotate, %0d reverse, %0d read.",
             cmd_seen[0] + cmd_seen[1] + cmd_seen[2] + cmd_seen[3],
             cmd_seen[CMD_APPEND], cmd_seen[CMD_ROTATE], cmd_seen[CMD_REVERSE],
             cmd_seen[CMD_READ]);
    $display("Sequence grew to %0d of %0d words; %0d appends hit a full store.",
             peak_len, DEPTH, full_hits);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/srrr_pkg.sv
rtl/srrr_ram.sv
rtl/sequence_range_reverse_rotate.sv
test/sequence_result_check.sv
test/testbench.sv
